[src/rds_pkg.sv]
// shared types, codes and constants of the render demand scheduler
package rds_pkg;

  localparam int unsigned SlotsDef   = 16;
  localparam int unsigned MaxResults = 16;
  localparam logic [63:0] SignBias   = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    OP_REG_CADENCED   = 3'd0,
    OP_REG_ONESHOT    = 3'd1,
    OP_REG_CONTINUOUS = 3'd2,
    OP_UNREGISTER     = 3'd3,
    OP_REQUEST        = 3'd4,
    OP_SET_ENABLE     = 3'd5,
    OP_EVALUATE       = 3'd6,
    OP_DELIVERED      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNKNOWN     = 3'd1,
    ST_BAD_CADENCE = 3'd2,
    ST_NOT_ONESHOT = 3'd3,
    ST_NOT_IN_PLAN = 3'd4,
    ST_FULL        = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MODE_CADENCED   = 2'd0,
    MODE_ONESHOT    = 2'd1,
    MODE_CONTINUOUS = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_END
  } state_e;

  // one consumer slot as held in the slot memory
  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  mode;
    logic [63:0] cadence;
    logic [63:0] delivered_ns;
    logic        requested;
    logic [7:0]  camera;
    logic        enabled;
  } slot_rec_t;

endpackage

[src/render_demand_scheduler.sv]
// render demand scheduler top level: consumer slot table and plan sequencer
//
// Commands enter on start_i with the operation fields; a transfer happens
// when start_i is high and busy_o is low. Results leave on result_*_o, each
// valid for one cycle under result_valid_o; last_o marks the final result
// of a command. The receiver takes every result; there is no back-pressure.
// Registration is handled on the accepting edge: its result is registered and
// shows in the next cycle, and busy_o stays low, so the next command may follow at once.
// Unregister, request, set enable and delivered scan the slot memory one
// slot per cycle and finish on the first match or after the last slot.
// Evaluate walks the registered slots in id order from an order list, one
// slot memory read per cycle, and stops at MaxResults results. Each due
// consumer's result is held until the next is found or the walk ends. The
// single read port of the slot memory sets this pace. Reset empties the table,
// clears the plan, sets the id counter to one and needs no clearing pass.
module render_demand_scheduler import rds_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         operation_i,
  input  logic [31:0]        consumer_id_i,
  input  logic signed [63:0] cadence_ns_i,
  input  logic [7:0]         camera_i,
  input  logic               enable_value_i,
  input  logic signed [63:0] sim_time_ns_i,
  output logic               result_valid_o,
  output logic [31:0]        result_id_o,
  output logic [2:0]         status_o,
  output logic               plan_empty_o,
  output logic               last_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned NW = $clog2(MaxResults + 1);

  state_e state_q, state_d;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [SLOTS-1:0] in_plan_q, in_plan_d;
  logic [SW-1:0]    order_q [SLOTS];
  logic [SW-1:0]    order_d [SLOTS];
  logic [CW-1:0]    count_q, count_d;
  logic [31:0]      id_ctr_q, id_ctr_d;
  logic [63:0]      plan_time_q, plan_time_d;

  op_e              op_q, op_d;
  logic [31:0]      cid_q, cid_d;
  logic [7:0]       cam_q, cam_d;
  logic             en_q, en_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic [SW-1:0]    rd_slot_q, rd_slot_d;
  logic             pend_q, pend_d;
  logic [31:0]      pend_id_q, pend_id_d;
  logic [NW-1:0]    n_q, n_d;

  logic             res_vld_q, res_vld_d;
  logic [31:0]      res_id_q, res_id_d;
  status_e          status_q, status_d;
  logic             empty_q, empty_d;
  logic             last_q, last_d;

  logic             mem_we;
  logic [SW-1:0]    mem_waddr;
  slot_rec_t        mem_wdata;
  logic [SW-1:0]    mem_raddr;
  slot_rec_t        rec;

  logic             accept;
  logic             issue;
  logic             hit;
  logic             due;
  logic             scan_drained;
  logic             look_end;
  logic             eval_end;
  logic             cap;
  logic [SW-1:0]    free_idx;
  logic             free_found;
  logic [63:0]      due_base;
  logic [64:0]      due_sum;

  rds_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rec)
  );

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_idx   = SW'(k);
        free_found = 1'b1;
      end
    end
  end

  // scan read issue and address
  always_comb begin
    issue     = 1'b0;
    mem_raddr = idx_q[SW-1:0];
    if (state_q == S_LOOK) begin
      issue = (idx_q < CW'(SLOTS));
    end else if (state_q == S_EVAL) begin
      issue     = (idx_q < count_q);
      mem_raddr = order_q[idx_q[SW-1:0]];
    end
  end

  // due test and lookup match on the slot just read
  always_comb begin
    due_base = rec.delivered_ns ^ SignBias;
    due_sum  = {1'b0, due_base} + {1'b0, rec.cadence};
    due      = 1'b0;
    if (rd_vld_q && rec.enabled && (rec.camera == 8'd0 || rec.camera == cam_q)) begin
      case (rec.mode)
        MODE_CONTINUOUS: due = 1'b1;
        MODE_ONESHOT:    due = rec.requested;
        MODE_CADENCED:   due = !due_sum[64] &&
                               ((plan_time_q ^ SignBias) >= due_sum[63:0]);
        default:         due = 1'b0;
      endcase
    end
    hit = rd_vld_q && (rec.id == cid_q) &&
          ((op_q == OP_DELIVERED) ? in_plan_q[rd_slot_q] : valid_q[rd_slot_q]);
    scan_drained = !issue && !rd_vld_q;
    look_end     = hit || scan_drained;
    cap          = due && ((n_q + NW'(pend_q)) == NW'(MaxResults - 1));
    eval_end     = cap || scan_drained;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_EVALUATE) begin
            state_d = S_EVAL;
          end else if (operation_i inside {OP_UNREGISTER, OP_REQUEST, OP_SET_ENABLE,
                                           OP_DELIVERED}) begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK:  if (look_end) state_d = S_IDLE;
      S_EVAL:  if (eval_end) state_d = S_END;
      S_END:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, table updates and results
  always_comb begin
    logic seen;
    valid_d     = valid_q;
    in_plan_d   = in_plan_q;
    order_d     = order_q;
    count_d     = count_q;
    id_ctr_d    = id_ctr_q;
    plan_time_d = plan_time_q;
    op_d        = op_q;
    cid_d       = cid_q;
    cam_d       = cam_q;
    en_d        = en_q;
    idx_d       = idx_q + CW'(issue);
    rd_vld_d    = issue;
    rd_slot_d   = mem_raddr;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    n_d         = n_q;
    res_vld_d   = 1'b0;
    res_id_d    = '0;
    status_d    = ST_OK;
    empty_d     = 1'b0;
    last_d      = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = rd_slot_q;
    mem_wdata   = rec;
    seen        = 1'b0;

    case (state_q)
      S_IDLE: begin
        idx_d    = '0;
        rd_vld_d = 1'b0;
        if (accept) begin
          op_d  = op_e'(operation_i);
          cid_d = consumer_id_i;
          cam_d = camera_i;
          en_d  = enable_value_i;
          if (operation_i inside {OP_REG_CADENCED, OP_REG_ONESHOT, OP_REG_CONTINUOUS})
          begin
            res_vld_d = 1'b1;
            if (operation_i == OP_REG_CADENCED &&
                (cadence_ns_i == 64'sd0 || cadence_ns_i[63])) begin
              status_d = ST_BAD_CADENCE;
            end else if (!free_found || id_ctr_q == 32'd0) begin
              status_d = ST_FULL;
            end else begin
              mem_we                  = 1'b1;
              mem_waddr               = free_idx;
              mem_wdata.id            = id_ctr_q;
              mem_wdata.mode          = operation_i[1:0];
              mem_wdata.cadence       = (operation_i == OP_REG_CADENCED) ?
                                        cadence_ns_i : 64'd0;
              mem_wdata.delivered_ns  = '0;
              mem_wdata.requested     = 1'b0;
              mem_wdata.camera        = camera_i;
              mem_wdata.enabled       = 1'b1;
              valid_d[free_idx]       = 1'b1;
              in_plan_d[free_idx]     = 1'b0;
              order_d[count_q[SW-1:0]] = free_idx;
              count_d                 = count_q + CW'(1);
              res_id_d                = id_ctr_q;
              id_ctr_d                = id_ctr_q + 32'd1;
            end
          end else if (operation_i == OP_EVALUATE) begin
            plan_time_d = sim_time_ns_i;
            in_plan_d   = '0;
            pend_d      = 1'b0;
            n_d         = '0;
          end
        end
      end
      S_LOOK: begin
        if (hit) begin
          res_vld_d = 1'b1;
          case (op_q)
            OP_UNREGISTER: begin
              valid_d[rd_slot_q] = 1'b0;
              // close the gap in the order list
              for (int k = 0; k < SLOTS; k++) begin
                if (CW'(k) < count_q && order_q[k] == rd_slot_q) begin
                  seen = 1'b1;
                end
                if (seen && k < SLOTS - 1) begin
                  order_d[k] = order_q[(k + 1) % SLOTS];
                end
              end
              count_d = count_q - CW'(1);
            end
            OP_REQUEST: begin
              if (rec.mode != MODE_ONESHOT) begin
                status_d = ST_NOT_ONESHOT;
              end else begin
                mem_we              = 1'b1;
                mem_wdata.requested = 1'b1;
              end
            end
            OP_SET_ENABLE: begin
              mem_we            = 1'b1;
              mem_wdata.enabled = en_q;
            end
            OP_DELIVERED: begin
              if (!valid_q[rd_slot_q]) begin
                status_d = ST_UNKNOWN;
              end else if (rec.mode == MODE_ONESHOT) begin
                mem_we              = 1'b1;
                mem_wdata.requested = 1'b0;
              end else if (rec.mode == MODE_CADENCED) begin
                mem_we                 = 1'b1;
                mem_wdata.delivered_ns = plan_time_q;
              end
            end
            default: status_d = ST_UNKNOWN;
          endcase
        end else if (scan_drained) begin
          res_vld_d = 1'b1;
          status_d  = (op_q == OP_DELIVERED) ? ST_NOT_IN_PLAN : ST_UNKNOWN;
        end
      end
      S_EVAL: begin
        if (due) begin
          in_plan_d[rd_slot_q] = 1'b1;
          if (pend_q) begin
            res_vld_d = 1'b1;
            res_id_d  = pend_id_q;
            last_d    = 1'b0;
            n_d       = n_q + NW'(1);
          end
          pend_d    = 1'b1;
          pend_id_d = rec.id;
        end
      end
      S_END: begin
        res_vld_d = 1'b1;
        if (pend_q) begin
          res_id_d = pend_id_q;
        end else begin
          empty_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      in_plan_q   <= '0;
      count_q     <= '0;
      id_ctr_q    <= 32'd1;
      plan_time_q <= '0;
      rd_vld_q    <= 1'b0;
      res_vld_q   <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      in_plan_q   <= in_plan_d;
      count_q     <= count_d;
      id_ctr_q    <= id_ctr_d;
      plan_time_q <= plan_time_d;
      rd_vld_q    <= rd_vld_d;
      res_vld_q   <= res_vld_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      n_q         <= n_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    order_q   <= order_d;
    op_q      <= op_d;
    cid_q     <= cid_d;
    cam_q     <= cam_d;
    en_q      <= en_d;
    rd_slot_q <= rd_slot_d;
    pend_id_q <= pend_id_d;
    res_id_q  <= res_id_d;
    status_q  <= status_d;
    empty_q   <= empty_d;
    last_q    <= last_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_id_o    = res_id_q;
  assign status_o       = status_q;
  assign plan_empty_o   = empty_q;
  assign last_o         = last_q;

`ifndef ASSERT_OFF
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && plan_empty_o |-> last_o && result_id_o == 32'd0)
    else $error("empty plan result not final");

  a_err_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> result_id_o == 32'd0)
    else $error("error result carries an id");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CW'($countones(valid_q)))
    else $error("order list length differs from valid slots");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == OP_EVALUATE |=> busy_o)
    else $error("evaluate did not hold busy");
`endif

endmodule

[src/rds_slot_mem.sv]
// slot record memory: one write port, one registered read port
module rds_slot_mem import rds_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDef,
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [SW-1:0]   waddr_i,
  input  slot_rec_t       wdata_i,
  input  logic [SW-1:0]   raddr_i,
  output slot_rec_t       rdata_o
);

  slot_rec_t mem_q [SLOTS];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
